/* hdl/assert_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, sampled on clk_i, off during reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// prop must hold at every edge out of reset
`define SFS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// prop must never hold out of reset
`define SFS_ASSERT_NEVER(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(prop)) else $error(msg);

`endif

/* hdl/sfscr_pkg.sv */
// ---------------------------------------------------------------------------
// sfscr_pkg
// Types and constants for the sensor frame sync and cliff reflex block.
// ---------------------------------------------------------------------------
package sfscr_pkg;

  localparam int unsigned PACKET_BYTES = 20;
  localparam int unsigned FILL_W       = $clog2(PACKET_BYTES);
  localparam int unsigned MAX_RESULTS  = 9;
  localparam int unsigned STEP_W       = $clog2(MAX_RESULTS);

  localparam logic [7:0] PKT_HEADER  = 8'd19;
  localparam logic [7:0] PKT_LEN     = 8'(PACKET_BYTES - 3);
  localparam logic [7:0] ID_CLIFF_L  = 8'd28;
  localparam logic [7:0] ID_CLIFF_FL = 8'd29;
  localparam logic [7:0] ID_CLIFF_FR = 8'd30;
  localparam logic [7:0] ID_CLIFF_R  = 8'd31;
  localparam logic [7:0] ID_DISTANCE = 8'd19;
  localparam logic [7:0] ID_IR       = 8'd17;

  localparam logic [7:0] CMD_DRIVE_DIRECT = 8'd145;
  localparam logic [7:0] CMD_STREAM_CTRL  = 8'd150;
  localparam logic [7:0] STREAM_PAUSE     = 8'd0;
  localparam logic [7:0] CMD_START        = 8'd128;

  localparam logic [8:0] SPEED_LIMIT = 9'd500;

  localparam logic [2:0] DRIVE_FWD   = 3'd0;
  localparam logic [2:0] DRIVE_LEFT  = 3'd1;
  localparam logic [2:0] DRIVE_RIGHT = 3'd2;
  localparam logic [2:0] DRIVE_BACK  = 3'd3;
  localparam logic [2:0] DRIVE_STOP  = 3'd4;
  localparam logic [2:0] DRIVE_EXIT  = 3'd5;

  localparam logic [2:0] REG_WHEEL_SPEED      = 3'd0;
  localparam logic [2:0] REG_THRESH_LEFT      = 3'd1;
  localparam logic [2:0] REG_THRESH_FRONT_L   = 3'd2;
  localparam logic [2:0] REG_THRESH_FRONT_R   = 3'd3;
  localparam logic [2:0] REG_THRESH_RIGHT     = 3'd4;
  localparam logic [2:0] REG_CLIFF_HIGH_VALUE = 3'd5;

  localparam logic [8:0] WHEEL_SPEED_RST = 9'd300;

  typedef enum logic [1:0] {
    KIND_RECORD    = 2'd0,
    KIND_COMMAND   = 2'd1,
    KIND_MISALIGNED = 2'd2
  } kind_e;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic [2:0] drive_request;
  } in_t;

  typedef struct packed {
    kind_e              kind;
    logic [7:0]         tx_byte;
    logic [3:0]         cliff_state;
    logic [15:0]        cliff_left_raw;
    logic [15:0]        cliff_front_left_raw;
    logic [15:0]        cliff_front_right_raw;
    logic [15:0]        cliff_right_raw;
    logic signed [15:0] distance;
    logic [7:0]         ir_byte;
    logic [2:0]         drive_requested;
    logic [2:0]         drive_issued;
    logic               last;
  } out_t;

  typedef struct packed {
    logic [8:0]  wheel_speed;
    logic [15:0] thresh_left;
    logic [15:0] thresh_front_left;
    logic [15:0] thresh_front_right;
    logic [15:0] thresh_right;
    logic        cliff_high_value;
  } cfg_t;

  typedef struct packed {
    logic               misaligned;
    logic [15:0]        cliff_left_raw;
    logic [15:0]        cliff_front_left_raw;
    logic [15:0]        cliff_front_right_raw;
    logic [15:0]        cliff_right_raw;
    logic signed [15:0] distance;
    logic [7:0]         ir_byte;
    logic [2:0]         drive_request;
  } job_t;

endpackage

/* hdl/sfscr_front.sv */
// ---------------------------------------------------------------------------
// sfscr_front
// Byte window, running checksum and frame check; posts one job per full window.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module sfscr_front import sfscr_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_stall_o,
  input  in_t   in_data_i,
  input  logic  queue_full_i,
  output logic  push_o,
  output job_t  job_o
);

  logic [7:0]        win_q [PACKET_BYTES];
  logic [7:0]        win_d [PACKET_BYTES];
  logic [FILL_W-1:0] fill_q, fill_d;
  logic [7:0]        sum_q, sum_d;
  logic [7:0]        sum_new;
  logic              accept;
  logic              full;
  logic              frame_ok;

  assign in_stall_o = queue_full_i;
  assign accept     = in_valid_i && !queue_full_i;
  assign sum_new    = sum_q + in_data_i.rx_byte;
  assign full       = (fill_q == FILL_W'(PACKET_BYTES - 1));

  always_comb begin
    for (int i = 0; i < PACKET_BYTES - 1; i++) begin
      win_d[i] = win_q[i+1];
    end
    win_d[PACKET_BYTES-1] = in_data_i.rx_byte;
  end

  assign frame_ok = (win_d[0] == PKT_HEADER) && (win_d[1] == PKT_LEN) &&
                    (win_d[2] == ID_CLIFF_L) && (win_d[5] == ID_CLIFF_FL) &&
                    (win_d[8] == ID_CLIFF_FR) && (win_d[11] == ID_CLIFF_R) &&
                    (win_d[14] == ID_DISTANCE) && (win_d[17] == ID_IR) &&
                    (sum_new == 8'd0);

  always_comb begin
    fill_d = fill_q;
    sum_d  = sum_q;
    push_o = 1'b0;
    if (accept) begin
      if (!full) begin
        fill_d = fill_q + 1'b1;
        sum_d  = sum_new;
      end else if (frame_ok) begin
        fill_d = '0;
        sum_d  = '0;
        push_o = 1'b1;
      end else begin
        // drop the oldest byte and resync
        fill_d = FILL_W'(PACKET_BYTES - 1);
        sum_d  = sum_new - win_d[0];
        push_o = 1'b1;
      end
    end
  end

  always_comb begin
    job_o                       = '0;
    job_o.misaligned            = !frame_ok;
    job_o.cliff_left_raw        = {win_d[3], win_d[4]};
    job_o.cliff_front_left_raw  = {win_d[6], win_d[7]};
    job_o.cliff_front_right_raw = {win_d[9], win_d[10]};
    job_o.cliff_right_raw       = {win_d[12], win_d[13]};
    job_o.distance              = {win_d[15], win_d[16]};
    job_o.ir_byte               = win_d[18];
    job_o.drive_request         = in_data_i.drive_request;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      sum_q  <= '0;
    end else begin
      fill_q <= fill_d;
      sum_q  <= sum_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      win_q <= win_d;
    end
  end

  `SFS_ASSERT_NEVER(a_fill_range, fill_q > FILL_W'(PACKET_BYTES - 1), "window fill overrun")
  `SFS_ASSERT(a_match_clears, push_o && !job_o.misaligned |=> fill_q == '0 && sum_q == '0,
              "window not emptied after a matching frame")

endmodule

/* hdl/sfscr_job_queue.sv */
// ---------------------------------------------------------------------------
// sfscr_job_queue
// Short FIFO of frame jobs between the front and back ends.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module sfscr_job_queue import sfscr_pkg::*; #(
  parameter int unsigned DEPTH = 2
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t job_i,
  output logic full_o,
  output logic valid_o,
  output job_t job_o,
  input  logic pop_i
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  job_t          mem_q [DEPTH];
  logic [AW-1:0] wr_ptr_q, wr_ptr_d;
  logic [AW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CW-1:0] count_q, count_d;
  logic          do_pop;

  assign full_o  = (count_q == CW'(DEPTH));
  assign valid_o = (count_q != '0);
  assign job_o   = mem_q[rd_ptr_q];
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (!push_i && do_pop) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

  `SFS_ASSERT_NEVER(a_no_overflow, push_i && full_o, "job pushed into a full queue")

endmodule

/* hdl/sfscr_back.sv */
// ---------------------------------------------------------------------------
// sfscr_back
// Cliff thresholds, drive reflex and result sequencer with output register.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module sfscr_back import sfscr_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  cfg_t cfg_i,
  input  logic job_valid_i,
  input  job_t job_i,
  output logic pop_o,
  output logic out_valid_o,
  input  logic out_stall_i,
  output out_t out_data_o
);

  logic [STEP_W-1:0] step_q, step_d;
  logic              out_valid_q, out_valid_d;
  out_t              out_q, res;
  logic              load;
  logic              bl, bfl, bfr, br;
  logic [3:0]        cliff;
  logic [2:0]        drive;
  logic [8:0]        speed;
  logic [15:0]       pos, neg, left, right;
  logic [STEP_W-1:0] n_res;
  logic              is_last;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign load        = job_valid_i && (!out_valid_q || !out_stall_i);

  always_comb begin
    bl    = (job_i.cliff_left_raw > cfg_i.thresh_left) ?
            cfg_i.cliff_high_value : !cfg_i.cliff_high_value;
    bfl   = (job_i.cliff_front_left_raw > cfg_i.thresh_front_left) ?
            cfg_i.cliff_high_value : !cfg_i.cliff_high_value;
    bfr   = (job_i.cliff_front_right_raw > cfg_i.thresh_front_right) ?
            cfg_i.cliff_high_value : !cfg_i.cliff_high_value;
    br    = (job_i.cliff_right_raw > cfg_i.thresh_right) ?
            cfg_i.cliff_high_value : !cfg_i.cliff_high_value;
    cliff = {bl, bfl, bfr, br};

    drive = job_i.drive_request;
    if (((drive == DRIVE_FWD) && (bfl || bfr)) || ((drive == DRIVE_BACK) && (bl || br)) ||
        ((drive == DRIVE_LEFT) && bl) || ((drive == DRIVE_RIGHT) && br)) begin
      drive = DRIVE_STOP;
    end
    if ((drive == DRIVE_STOP) && (cliff == 4'd0)) begin
      drive = DRIVE_LEFT;
    end

    speed = (cfg_i.wheel_speed > SPEED_LIMIT) ? SPEED_LIMIT : cfg_i.wheel_speed;
    pos   = {7'd0, speed};
    neg   = 16'd0 - pos;
    case (drive)
      DRIVE_FWD: begin
        left  = pos;
        right = pos;
      end
      DRIVE_LEFT: begin
        left  = neg;
        right = pos;
      end
      DRIVE_RIGHT: begin
        left  = pos;
        right = neg;
      end
      DRIVE_BACK: begin
        left  = neg;
        right = neg;
      end
      default: begin
        left  = '0;
        right = '0;
      end
    endcase

    if (job_i.misaligned) begin
      n_res = STEP_W'(1);
    end else if (drive == DRIVE_EXIT) begin
      n_res = STEP_W'(9);
    end else if (drive < DRIVE_EXIT) begin
      n_res = STEP_W'(6);
    end else begin
      n_res = STEP_W'(1);
    end
    is_last = (step_q == n_res - 1'b1);
  end

  always_comb begin
    res      = '0;
    res.last = is_last;
    if (job_i.misaligned) begin
      res.kind = KIND_MISALIGNED;
    end else if (step_q == '0) begin
      res.kind                  = KIND_RECORD;
      res.cliff_state           = cliff;
      res.cliff_left_raw        = job_i.cliff_left_raw;
      res.cliff_front_left_raw  = job_i.cliff_front_left_raw;
      res.cliff_front_right_raw = job_i.cliff_front_right_raw;
      res.cliff_right_raw       = job_i.cliff_right_raw;
      res.distance              = job_i.distance;
      res.ir_byte               = job_i.ir_byte;
      res.drive_requested       = job_i.drive_request;
      res.drive_issued          = drive;
    end else begin
      res.kind = KIND_COMMAND;
      case (step_q)
        STEP_W'(1): res.tx_byte = CMD_DRIVE_DIRECT;
        STEP_W'(2): res.tx_byte = right[15:8];
        STEP_W'(3): res.tx_byte = right[7:0];
        STEP_W'(4): res.tx_byte = left[15:8];
        STEP_W'(5): res.tx_byte = left[7:0];
        STEP_W'(6): res.tx_byte = CMD_STREAM_CTRL;
        STEP_W'(7): res.tx_byte = STREAM_PAUSE;
        STEP_W'(8): res.tx_byte = CMD_START;
        default:    res.tx_byte = '0;
      endcase
    end
  end

  always_comb begin
    step_d      = step_q;
    out_valid_d = out_valid_q;
    pop_o       = 1'b0;
    if (load) begin
      out_valid_d = 1'b1;
      if (is_last) begin
        step_d = '0;
        pop_o  = 1'b1;
      end else begin
        step_d = step_q + 1'b1;
      end
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q <= res;
    end
  end

  `SFS_ASSERT(a_step_range, step_q < STEP_W'(MAX_RESULTS), "result step out of range")
  `SFS_ASSERT(a_job_held, step_q != '0 |-> job_valid_i, "job left the queue mid-sequence")

endmodule

/* hdl/sensor_frame_sync_and_cliff_reflex.sv */
// ---------------------------------------------------------------------------
// sensor_frame_sync_and_cliff_reflex
// Sensor stream deframer with checksum, cliff thresholds and drive reflex.
// ---------------------------------------------------------------------------
// Takes one received byte per cycle. A byte that leaves the 20-byte window
// short of full gives no result. A full window is checked and posted as one
// job into a queue of JOB_DEPTH entries; the back end then delivers one result
// per cycle from its output register while not stalled: one for a misaligned
// window or an invalid drive request, six for a drive, nine for exit. Input
// stalls only while the job queue is full, so the sustained rate is one byte
// a cycle unless frames arrive faster than the back end drains their results.
// Configuration takes effect on jobs being sequenced, so write it while idle.

module sensor_frame_sync_and_cliff_reflex import sfscr_pkg::*; #(
  parameter int unsigned JOB_DEPTH = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  in_t         in_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output out_t        out_data_o,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [15:0] cfg_wdata_i
);

  cfg_t cfg_q, cfg_d;
  logic push;
  job_t push_job;
  logic q_full;
  logic q_valid;
  job_t q_job;
  logic pop;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_index_i)
        REG_WHEEL_SPEED:      cfg_d.wheel_speed        = cfg_wdata_i[8:0];
        REG_THRESH_LEFT:      cfg_d.thresh_left        = cfg_wdata_i;
        REG_THRESH_FRONT_L:   cfg_d.thresh_front_left  = cfg_wdata_i;
        REG_THRESH_FRONT_R:   cfg_d.thresh_front_right = cfg_wdata_i;
        REG_THRESH_RIGHT:     cfg_d.thresh_right       = cfg_wdata_i;
        REG_CLIFF_HIGH_VALUE: cfg_d.cliff_high_value   = cfg_wdata_i[0];
        default:              cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{wheel_speed:        WHEEL_SPEED_RST,
                 thresh_left:        16'd0,
                 thresh_front_left:  16'd0,
                 thresh_front_right: 16'd0,
                 thresh_right:       16'd0,
                 cliff_high_value:   1'b1};
    end else begin
      cfg_q <= cfg_d;
    end
  end

  sfscr_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_data_i    (in_data_i),
    .queue_full_i (q_full),
    .push_o       (push),
    .job_o        (push_job)
  );

  sfscr_job_queue #(
    .DEPTH (JOB_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (push_job),
    .full_o  (q_full),
    .valid_o (q_valid),
    .job_o   (q_job),
    .pop_i   (pop)
  );

  sfscr_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .job_valid_i (q_valid),
    .job_i       (q_job),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule
